/* hw/rtl/cfm_pkg.sv */
package cfm_pkg;

	localparam int FP_W    = 8;   // stored fingerprint width
	localparam int CNT_W   = 13;  // occupancy counter width
	localparam int KICK_W  = 12;
	localparam int FPB_W   = 4;
	localparam int CFG_W   = 12;  // widest register
	localparam int HASH_W  = 64;

	// request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_QUERY  = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	// register indexes
	localparam logic CFG_FP_BITS   = 1'b0;
	localparam logic CFG_MAX_KICKS = 1'b1;

	localparam logic [FPB_W-1:0]  FP_BITS_RST   = 4'd8;
	localparam logic [KICK_W-1:0] MAX_KICKS_RST = 12'd500;

	typedef logic [FP_W-1:0] fp_t;

endpackage

/* hw/rtl/cfm_bucket_mem.sv */
module cfm_bucket_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/cuckoo_filter_membership.sv */
// Query, remove and insert into a free slot go from the accepted word through the read of
// bucket one and, if needed, bucket two to the result word, after an index reduction over the
// hash bytes when NUM_BUCKETS is not a power of two. Each eviction step of an insert is a
// read-modify-write of the current bucket, then alternate index and read of the next, up to
// max_kicks steps (one when max_kicks is zero). One request at a time: in_ready stays low
// until the request in flight reaches its result word. Reset: registers load their defaults,
// then a clearing pass zeroes every bucket row with in_ready low.
module cuckoo_filter_membership #(
	parameter int NUM_BUCKETS  = 1024,
	parameter int BUCKET_SLOTS = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [cfm_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     req_type,
	input  logic [cfm_pkg::HASH_W-1:0]     index_hash,
	input  logic [cfm_pkg::FP_W-1:0]       fp_hash,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           success,
	output logic [cfm_pkg::CNT_W-1:0]      occupied_count
);

	localparam int IW      = NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1;
	localparam int SW      = BUCKET_SLOTS > 1 ? $clog2(BUCKET_SLOTS) : 1;
	localparam int FW      = cfm_pkg::FP_W;
	localparam int ROW_W   = BUCKET_SLOTS * FW;
	localparam int XW      = IW + FW + 1;
	localparam bit IS_POW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;
	localparam logic [IW-1:0] IDX_MASK = IW'(NUM_BUCKETS - 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BUCKETS - 1);
	localparam logic [SW-1:0] LAST_SLOT = SW'(BUCKET_SLOTS - 1);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_REDUCE, S_RD1, S_B1, S_B2, S_KICK, S_KALT, S_KPLACE, S_OUT
	} state_t;

	// (idx ^ fp) mod NUM_BUCKETS; the operand stays below 256 * NUM_BUCKETS
	function automatic logic [IW-1:0] alt_idx(input logic [IW-1:0] idx,
			input logic [FW-1:0] fp);
		logic [XW-1:0] x;
		logic [XW-1:0] d;
		x = XW'(idx) ^ XW'(fp);
		for (int k = 7; k >= 0; k--) begin
			d = XW'(NUM_BUCKETS) << k;
			if (x >= d) begin
				x = x - d;
			end
		end
		return x[IW-1:0];
	endfunction

	// remainder update over one byte of the hash, MSB first
	function automatic logic [IW-1:0] mod_byte(input logic [IW-1:0] r,
			input logic [7:0] b);
		logic [IW:0] t;
		t = {1'b0, r};
		for (int j = 7; j >= 0; j--) begin
			t = {t[IW-1:0], b[j]};
			if (t >= (IW+1)'(NUM_BUCKETS)) begin
				t = t - (IW+1)'(NUM_BUCKETS);
			end
		end
		return t[IW-1:0];
	endfunction

	state_t                       state_q;
	logic [FW-1:0]                fp_q;
	logic [1:0]                   req_q;
	logic [IW-1:0]                idx1_q;
	logic [IW-1:0]                idx2_q;
	logic [IW-1:0]                cur_q;
	logic [IW-1:0]                clr_q;
	logic [FW-1:0]                hand_q;
	logic [cfm_pkg::KICK_W-1:0]   kick_q;
	logic [SW-1:0]                slot_q;
	logic [cfm_pkg::HASH_W-1:0]   hash_q;
	logic [2:0]                   byte_q;
	logic [cfm_pkg::CNT_W-1:0]    occ_q;
	logic                         res_ok_q;
	logic                         out_valid_q;
	logic                         success_q;
	logic [cfm_pkg::CNT_W-1:0]    count_q;
	logic [cfm_pkg::FPB_W-1:0]    fp_bits_q;
	logic [cfm_pkg::KICK_W-1:0]   max_kicks_q;

	logic [ROW_W-1:0]             row;
	logic                         hit_fp;
	logic                         hit_zero;
	logic [SW-1:0]                slot_fp;
	logic [SW-1:0]                slot_zero;
	logic [FW-1:0]                victim;
	logic [IW-1:0]                alt_nxt;
	logic [cfm_pkg::FPB_W-1:0]    bits_eff;
	logic [FW-1:0]                fp_in;
	logic [FW-1:0]                fp_masked;
	logic [cfm_pkg::KICK_W-1:0]   lim_m1;
	logic                         mem_we;
	logic [IW-1:0]                mem_waddr;
	logic [ROW_W-1:0]             mem_wdata;
	logic                         mem_re;
	logic [IW-1:0]                mem_raddr;

	cfm_bucket_mem #(
		.DEPTH (NUM_BUCKETS),
		.WIDTH (ROW_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (row)
	);

	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = out_valid_q;
	assign success        = success_q;
	assign occupied_count = count_q;

	always_comb begin
		bits_eff = fp_bits_q;
		if (fp_bits_q == '0) begin
			bits_eff = 4'd1;
		end else if (fp_bits_q > 4'd8) begin
			bits_eff = 4'd8;
		end
		fp_masked = fp_hash & (8'hFF >> (4'd8 - bits_eff));
		fp_in     = (fp_masked == '0) ? 8'd1 : fp_masked;
		lim_m1    = (max_kicks_q == '0) ? '0 : max_kicks_q - 1'b1;
	end

	// slot search on the row just read, lowest slot first
	always_comb begin
		hit_fp    = 1'b0;
		hit_zero  = 1'b0;
		slot_fp   = '0;
		slot_zero = '0;
		for (int s = BUCKET_SLOTS - 1; s >= 0; s--) begin
			if (row[s*FW +: FW] == fp_q) begin
				hit_fp  = 1'b1;
				slot_fp = SW'(s);
			end
			if (row[s*FW +: FW] == '0) begin
				hit_zero  = 1'b1;
				slot_zero = SW'(s);
			end
		end
		victim  = row[slot_q*FW +: FW];
		alt_nxt = alt_idx(cur_q, hand_q);
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = row;
		mem_re    = 1'b0;
		mem_raddr = idx1_q;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_RD1: begin
				mem_re = 1'b1;
			end
			S_B1, S_B2: begin
				mem_waddr = (state_q == S_B1) ? idx1_q : idx2_q;
				if (state_q == S_B1) begin
					mem_re    = 1'b1;
					mem_raddr = idx2_q;
				end else if (req_q == cfm_pkg::REQ_INSERT && !hit_zero) begin
					mem_re    = 1'b1;
					mem_raddr = idx1_q;
				end
				if (req_q == cfm_pkg::REQ_INSERT && hit_zero) begin
					mem_we                      = 1'b1;
					mem_wdata[slot_zero*FW +: FW] = fp_q;
				end else if (req_q == cfm_pkg::REQ_REMOVE && hit_fp) begin
					mem_we                    = 1'b1;
					mem_wdata[slot_fp*FW +: FW] = '0;
				end
			end
			S_KICK: begin
				mem_we                   = 1'b1;
				mem_wdata[slot_q*FW +: FW] = hand_q;
			end
			S_KALT: begin
				mem_re    = 1'b1;
				mem_raddr = alt_nxt;
			end
			S_KPLACE: begin
				if (hit_zero) begin
					mem_we                      = 1'b1;
					mem_wdata[slot_zero*FW +: FW] = hand_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
			fp_bits_q   <= cfm_pkg::FP_BITS_RST;
			max_kicks_q <= cfm_pkg::MAX_KICKS_RST;
			kick_q      <= '0;
			slot_q      <= '0;
			byte_q      <= '0;
			fp_q        <= '0;
			req_q       <= '0;
			idx1_q      <= '0;
			idx2_q      <= '0;
			cur_q       <= '0;
			hand_q      <= '0;
			hash_q      <= '0;
			res_ok_q    <= 1'b0;
			success_q   <= 1'b0;
			count_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cfm_pkg::CFG_FP_BITS:   fp_bits_q   <= cfg_wdata[cfm_pkg::FPB_W-1:0];
					cfm_pkg::CFG_MAX_KICKS: max_kicks_q <= cfg_wdata[cfm_pkg::KICK_W-1:0];
					default: begin
					end
				endcase
			end
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						fp_q   <= fp_in;
						req_q  <= req_type;
						hash_q <= index_hash;
						byte_q <= '0;
						if (IS_POW2) begin
							idx1_q <= index_hash[IW-1:0] & IDX_MASK;
						end else begin
							idx1_q <= '0;
						end
						if (req_type inside {cfm_pkg::REQ_INSERT, cfm_pkg::REQ_QUERY,
								cfm_pkg::REQ_REMOVE}) begin
							state_q <= IS_POW2 ? S_RD1 : S_REDUCE;
						end else begin
							res_ok_q <= 1'b0;
							state_q  <= S_OUT;
						end
					end
				end
				S_REDUCE: begin
					idx1_q <= mod_byte(idx1_q, hash_q[cfm_pkg::HASH_W-1 -: 8]);
					hash_q <= hash_q << 8;
					byte_q <= byte_q + 1'b1;
					if (byte_q == 3'd7) begin
						state_q <= S_RD1;
					end
				end
				S_RD1: begin
					idx2_q  <= alt_idx(idx1_q, fp_q);
					state_q <= S_B1;
				end
				S_B1, S_B2: begin
					case (req_q)
						cfm_pkg::REQ_QUERY: begin
							if (hit_fp) begin
								res_ok_q <= 1'b1;
								state_q  <= S_OUT;
							end else begin
								res_ok_q <= 1'b0;
								state_q  <= (state_q == S_B1) ? S_B2 : S_OUT;
							end
						end
						cfm_pkg::REQ_REMOVE: begin
							if (hit_fp) begin
								occ_q    <= occ_q - 1'b1;
								res_ok_q <= 1'b1;
								state_q  <= S_OUT;
							end else begin
								res_ok_q <= 1'b0;
								state_q  <= (state_q == S_B1) ? S_B2 : S_OUT;
							end
						end
						cfm_pkg::REQ_INSERT: begin
							if (hit_zero) begin
								occ_q    <= occ_q + 1'b1;
								res_ok_q <= 1'b1;
								state_q  <= S_OUT;
							end else if (state_q == S_B2) begin
								// both buckets full: start the eviction walk at bucket one
								cur_q    <= idx1_q;
								hand_q   <= fp_q;
								kick_q   <= '0;
								slot_q   <= '0;
								res_ok_q <= 1'b0;
								state_q  <= S_KICK;
							end else begin
								res_ok_q <= 1'b0;
								state_q  <= S_B2;
							end
						end
						default: begin
							res_ok_q <= 1'b0;
							state_q  <= S_OUT;
						end
					endcase
				end
				S_KICK: begin
					hand_q  <= victim;
					slot_q  <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
					state_q <= S_KALT;
				end
				S_KALT: begin
					cur_q   <= alt_nxt;
					state_q <= S_KPLACE;
				end
				S_KPLACE: begin
					if (hit_zero) begin
						occ_q    <= occ_q + 1'b1;
						res_ok_q <= 1'b1;
						state_q  <= S_OUT;
					end else if (kick_q == lim_m1) begin
						// hand is dropped; occupancy unchanged
						res_ok_q <= 1'b0;
						state_q  <= S_OUT;
					end else begin
						// row of cur_q is still on the read port
						kick_q  <= kick_q + 1'b1;
						state_q <= S_KICK;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						success_q   <= res_ok_q;
						count_q     <= occ_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
